@@ rtl/spq_pkg.sv @@
// Package: shared types, sizes and codes of the sorted priority queue.
`default_nettype none
package spq_pkg;

    // Queue capacity and derived widths
    localparam int DEPTH          = 16;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int ENTRY_COUNT_W  = 5;
    localparam logic [ENTRY_COUNT_W-1:0] FULL_COUNT = ENTRY_COUNT_W'(DEPTH);

    // Operation codes
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // Response status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Request payload
    typedef struct packed {
        logic               mode;
        logic signed [31:0] item_value;
        logic signed [15:0] item_priority;
    } t_req;

    // Response payload
    typedef struct packed {
        logic [1:0]               status;
        logic signed [31:0]       out_value;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } t_rsp;

    // One stored queue entry
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } t_entry;

    // Control broadcast to every cell
    typedef struct packed {
        logic   enq;
        logic   deq;
        t_entry item;
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ rtl/spq_if.sv @@
// Interfaces: request and response channels of the sorted priority queue.
`default_nettype none
interface spq_req_if;
    logic          valid;
    logic          ready;
    spq_pkg::t_req payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

interface spq_rsp_if;
    logic          valid;
    logic          ready;
    spq_pkg::t_rsp payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/spq_cell.sv @@
// Cell: one slot of the sorted chain, exchanging entries with its neighbors.
`default_nettype none
module spq_cell (
    input  wire logic               i_clk,
    input  wire spq_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_occupied,
    input  wire spq_pkg::t_entry    i_left_entry,
    input  wire logic               i_left_ge,
    input  wire spq_pkg::t_entry    i_right_entry,
    output spq_pkg::t_entry         o_entry,
    output logic                    o_ge
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // Flag a stored entry that stays ahead of the incoming one
    assign o_ge    = i_occupied && (r_entry.prio >= i_ctl.item.prio);
    assign o_entry = r_entry;

    // Hold, take the new item, shift down from the left, or shift up from the right
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq) begin
            if (o_ge) begin
                n_entry = r_entry;
            end else if (i_left_ge) begin
                n_entry = i_ctl.item;
            end else begin
                n_entry = i_left_entry;
            end
        end else if (i_ctl.deq) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

@@ rtl/sorted_priority_queue_unit.sv @@
// A response is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while responses are taken; the single
// response register stalls the request side only while a response waits.
// Every cell compares against the incoming priority in the same cycle.
// Reset clears the entry count and the response valid; slot contents are not reset.
`default_nettype none
module sorted_priority_queue_unit (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    spq_req_if.sink      i_req,
    spq_rsp_if.source    o_rsp
);

    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] n_count;
    logic                      r_rsp_valid;
    spq_pkg::t_rsp             r_rsp;
    spq_pkg::t_rsp             n_rsp;

    logic                      accept;
    logic                      full;
    logic                      empty;
    spq_pkg::t_cell_ctl        ctl;
    logic [spq_pkg::CNT_W+spq_pkg::ENTRY_COUNT_W-1:0] count_ext;

    spq_pkg::t_entry           cell_entry [spq_pkg::DEPTH];
    logic                      cell_ge    [spq_pkg::DEPTH];

    // Take a request whenever the response register is free or draining
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign full  = (r_count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
    assign empty = (r_count == '0);

    // Broadcast the operation to the chain
    always_comb begin
        ctl.enq        = accept && (i_req.payload.mode == spq_pkg::MODE_ENQ) && !full;
        ctl.deq        = accept && (i_req.payload.mode == spq_pkg::MODE_DEQ) && !empty;
        ctl.item.value = i_req.payload.item_value;
        ctl.item.prio  = i_req.payload.item_priority;
    end

    // Chain of cells, head (highest priority) at slot zero
    for (genvar g = 0; g < spq_pkg::DEPTH; g++) begin : g_cell
        spq_pkg::t_entry left_entry;
        spq_pkg::t_entry right_entry;
        logic            left_ge;

        if (g == 0) begin : g_head
            assign left_entry = '0;
            assign left_ge    = 1'b1;
        end else begin : g_body
            assign left_entry = cell_entry[g-1];
            assign left_ge    = cell_ge[g-1];
        end

        if (g == spq_pkg::DEPTH - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = cell_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_occupied    (r_count > spq_pkg::CNT_W'(g)),
            .i_left_entry  (left_entry),
            .i_left_ge     (left_ge),
            .i_right_entry (right_entry),
            .o_entry       (cell_entry[g]),
            .o_ge          (cell_ge[g])
        );
    end

    // Advance the count
    always_comb begin
        n_count = r_count;
        if (ctl.enq) begin
            n_count = r_count + 1'b1;
        end else if (ctl.deq) begin
            n_count = r_count - 1'b1;
        end
    end

    assign count_ext = {{spq_pkg::ENTRY_COUNT_W{1'b0}}, n_count};

    // Build the response
    always_comb begin
        n_rsp.status      = spq_pkg::ST_OK;
        n_rsp.out_value   = '0;
        n_rsp.entry_count = count_ext[spq_pkg::ENTRY_COUNT_W-1:0];
        if (i_req.payload.mode == spq_pkg::MODE_ENQ) begin
            if (full) begin
                n_rsp.status = spq_pkg::ST_FULL;
            end
        end else begin
            if (empty) begin
                n_rsp.status    = spq_pkg::ST_EMPTY;
                n_rsp.out_value = '1;
            end else begin
                n_rsp.out_value = cell_entry[0].value;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

endmodule
`default_nettype wire

@@ rtl/spq_checker.sv @@
// Checker: port-level properties of the sorted priority queue, bound to the top level.
`default_nettype none
module spq_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_rsp_valid,
    input wire logic          i_rsp_ready,
    input wire spq_pkg::t_rsp i_rsp
);

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("stalled response changed");

    // An empty dequeue reports all ones and no entries
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp.status == spq_pkg::ST_EMPTY) |->
            (i_rsp.out_value == -32'sd1) && (i_rsp.entry_count == '0))
        else $error("empty response malformed");

    // A rejected enqueue reports a full queue and a zero value
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp.status == spq_pkg::ST_FULL) |->
            (i_rsp.out_value == '0) && (i_rsp.entry_count == spq_pkg::FULL_COUNT))
        else $error("full response malformed");

    // Drop any response after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);
`default_nettype wire
